// ----- design/spt_pkg.sv -----
// Shared constants, types and the multiplier stage count for the stereo point triangulator.
// Used by the multiplier, the determinant, the divider and the top level; no dependencies.
package spt_pkg;

	localparam int COEF_WIDTH_DEF = 40;
	localparam int PIX_FRAC_DEF   = 4;
	localparam int NUM_COEF       = 24;
	localparam int IDX_W          = 5;
	localparam int PIX_W          = 16;
	// Result fraction bits; one more bit is used for round to nearest.
	localparam int OUT_FRAC       = 16;
	// Operand chunk width of one multiplier stage.
	localparam int MUL_CHUNK      = 30;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_SOLVE = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_SINGULAR = 2'd1,
		STAT_SAT      = 2'd2
	} status_t;

	// Flags that leave a divider with its quotient.
	typedef struct packed {
		logic sat;
		logic zero;
	} div_flags_t;

	// Pipeline depth of spt_mul: one chunk-by-chunk product per stage.
	function automatic int mul_stages(input int aw, input int bw);
		return ((aw + MUL_CHUNK - 1) / MUL_CHUNK) * ((bw + MUL_CHUNK - 1) / MUL_CHUNK);
	endfunction

endpackage

// ----- design/stereo_point_triangulator.sv -----
// Each item passes the input registers, the chunked multipliers, the normal-equation sums,
// the determinants and the one-bit-per-stage quotient pipeline, in that order.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// A load item writes its coefficient at acceptance and causes no result.
// Reset clears the valid bits only; the coefficient store is undefined until written.
// Depends on spt_pkg, spt_mul, spt_det3 and spt_div.
module stereo_point_triangulator #(
	parameter int COEF_WIDTH      = spt_pkg::COEF_WIDTH_DEF,
	parameter int PIXEL_FRAC_BITS = spt_pkg::PIX_FRAC_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// coef_index, coef_value, left_u, left_v, right_u, right_v, zero fill
	input  logic [((spt_pkg::IDX_W + COEF_WIDTH + 4*spt_pkg::PIX_W + 7) / 8) * 8 - 1:0] s_tdata,
	// command
	input  logic s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// world_x, world_y, world_z, zero fill
	output logic [((3 * COEF_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,
	// status
	output spt_pkg::status_t m_tuser
);
	import spt_pkg::*;

	localparam int CW    = COEF_WIDTH;
	localparam int OUT_W = ((3 * CW + 7) / 8) * 8;
	localparam int AW    = CW + PIX_W + 2;
	localparam int NW    = 2 * AW + 2;
	localparam int DW    = 3 * NW + 3;
	localparam int NM    = mul_stages(AW, AW);
	localparam int N1    = mul_stages(NW, NW);
	localparam int N2    = mul_stages(2 * NW + 1, NW);
	localparam int LAT   = 2 + NM + 1 + (N1 + N2 + 2) + (CW + 2);

	localparam int OFF_COEF = IDX_W;
	localparam int OFF_PIX  = IDX_W + CW;

	// Entry pairs of the normal equations: six of A^T A, then three of A^T B.
	localparam int EI [9] = '{0, 0, 0, 1, 1, 2, 0, 1, 2};
	localparam int EJ [9] = '{0, 1, 2, 1, 2, 2, 0, 0, 0};
	localparam int NIDX [3][3] = '{'{0, 1, 2}, '{1, 3, 4}, '{2, 4, 5}};

	logic en, accept;
	logic [IDX_W-1:0]     in_idx;
	logic signed [CW-1:0] in_coef;

	logic signed [CW-1:0] coef_q [NUM_COEF];
	logic [LAT-1:0]       vld_q;

	logic [PIX_W-1:0]     pix_s1  [4];
	logic signed [CW-1:0] coef_s1 [NUM_COEF];
	logic signed [AW-1:0] a_s2    [4][3];
	logic signed [AW-1:0] b_s2    [4];
	logic signed [2*AW-1:0] prod  [9][4];
	logic signed [NW-1:0] n_s4    [9];
	logic signed [NW-1:0] dmat    [4][9];
	logic signed [DW-1:0] det     [4];
	logic signed [CW-1:0] coord   [3];
	div_flags_t           dflags  [3];

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign accept   = s_tvalid && en;
	assign in_idx   = s_tdata[IDX_W-1:0];
	assign in_coef  = s_tdata[OFF_COEF +: CW];

	// Coefficient store, written by load items.
	always_ff @(posedge clk) begin
		if (accept && (s_tuser == CMD_LOAD)) begin
			for (int i = 0; i < NUM_COEF; i++) begin
				if (in_idx == IDX_W'(i)) begin
					coef_q[i] <= in_coef;
				end
			end
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], accept && (s_tuser == CMD_SOLVE)};
		end
	end

	// Stage 1: capture the pixels and a snapshot of the matrices.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				pix_s1[i] <= s_tdata[OFF_PIX + i*PIX_W +: PIX_W];
			end
			coef_s1 <= coef_q;
		end
	end

	// Stage 2: rows of A and entries of B, one row per pixel coordinate.
	for (genvar k = 0; k < 4; k++) begin : g_row
		localparam int BASE = (k / 2) * 12;
		localparam int RSEL = k % 2;
		logic signed [PIX_W:0] pw;

		assign pw = $signed({1'b0, pix_s1[k]});

		always_ff @(posedge clk) begin
			if (en) begin
				for (int j = 0; j < 3; j++) begin
					a_s2[k][j] <= pw * coef_s1[BASE + 8 + j]
						- (AW'(coef_s1[BASE + 4*RSEL + j]) <<< PIXEL_FRAC_BITS);
				end
				b_s2[k] <= (AW'(coef_s1[BASE + 4*RSEL + 3]) <<< PIXEL_FRAC_BITS)
					- pw * coef_s1[BASE + 11];
			end
		end
	end

	// Products for the normal equations.
	for (genvar e = 0; e < 9; e++) begin : g_ent
		for (genvar k = 0; k < 4; k++) begin : g_k
			if (e < 6) begin : g_ata
				spt_mul #(.AW(AW), .BW(AW)) u_m (
					.clk, .en, .a(a_s2[k][EI[e]]), .b(a_s2[k][EJ[e]]), .p(prod[e][k])
				);
			end else begin : g_atb
				spt_mul #(.AW(AW), .BW(AW)) u_m (
					.clk, .en, .a(a_s2[k][EI[e]]), .b(b_s2[k]), .p(prod[e][k])
				);
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_s4[e] <= NW'(prod[e][0]) + NW'(prod[e][1])
					+ NW'(prod[e][2]) + NW'(prod[e][3]);
			end
		end
	end

	// The system determinant and the three Cramer determinants.
	for (genvar d = 0; d < 4; d++) begin : g_det
		for (genvar r = 0; r < 3; r++) begin : g_r
			for (genvar c = 0; c < 3; c++) begin : g_c
				if (d > 0 && c == d - 1) begin : g_v
					assign dmat[d][3*r + c] = n_s4[6 + r];
				end else begin : g_n
					assign dmat[d][3*r + c] = n_s4[NIDX[r][c]];
				end
			end
		end

		spt_det3 #(.EW(NW)) u_det (
			.clk, .en, .m(dmat[d]), .r(det[d])
		);
	end

	for (genvar k = 0; k < 3; k++) begin : g_div
		spt_div #(.DW(DW), .QW(CW)) u_div (
			.clk, .en, .num(det[k+1]), .den(det[0]), .q(coord[k]), .flags(dflags[k])
		);
	end

	// Result item: zeros with a singular system, else the clamped point.
	assign m_tvalid = vld_q[LAT-1];

	always_comb begin
		if (dflags[0].zero) begin
			m_tdata = '0;
			m_tuser = STAT_SINGULAR;
		end else begin
			m_tdata = OUT_W'({coord[2], coord[1], coord[0]});
			if (dflags[0].sat || dflags[1].sat || dflags[2].sat) begin
				m_tuser = STAT_SAT;
			end else begin
				m_tuser = STAT_OK;
			end
		end
	end

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (s_tuser == CMD_LOAD) |=> !vld_q[0])
		else $error("load item entered the solve pipeline");

	a_solve_enters: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (s_tuser == CMD_SOLVE) |=> vld_q[0])
		else $error("solve item did not enter the pipeline");

	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == STAT_SINGULAR) |-> (m_tdata == '0))
		else $error("singular result carries nonzero coordinates");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline valid bits moved during a stall");

endmodule

// ----- design/spt_mul.sv -----
// Pipelined signed multiplier: one chunk-by-chunk partial product per register stage.
// Depends on spt_pkg for the chunk width and the stage count.
module spt_mul #(
	parameter int AW = 58,
	parameter int BW = 58
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [AW-1:0]    a,
	input  logic signed [BW-1:0]    b,
	output logic signed [AW+BW-1:0] p
);
	import spt_pkg::*;

	localparam int CK   = MUL_CHUNK;
	localparam int NA   = (AW + CK - 1) / CK;
	localparam int NB   = (BW + CK - 1) / CK;
	localparam int NSTG = mul_stages(AW, BW);
	localparam int AX   = NA * CK;
	localparam int BX   = NB * CK;
	localparam int PW   = AX + BX;
	localparam int PPW  = 2 * CK + 2;

	logic signed [AX-1:0] aext;
	logic signed [BX-1:0] bext;
	logic signed [AX-1:0] a_r   [NSTG-1];
	logic signed [BX-1:0] b_r   [NSTG-1];
	logic signed [PW-1:0] acc_r [NSTG];

	assign aext = AX'(a);
	assign bext = BX'(b);

	// Each stage adds one chunk product; only the top chunk of each operand is signed.
	for (genvar s = 0; s < NSTG; s++) begin : g_stg
		localparam int IA = s % NA;
		localparam int IB = s / NA;
		logic signed [AX-1:0]  a_in;
		logic signed [BX-1:0]  b_in;
		logic signed [PW-1:0]  acc_in;
		logic signed [CK:0]    ca;
		logic signed [CK:0]    cb;
		logic signed [PPW-1:0] pp;

		if (s == 0) begin : g_first
			assign a_in   = aext;
			assign b_in   = bext;
			assign acc_in = '0;
		end else begin : g_next
			assign a_in   = a_r[s-1];
			assign b_in   = b_r[s-1];
			assign acc_in = acc_r[s-1];
		end

		assign ca = $signed({(IA == NA - 1) ? a_in[AX-1] : 1'b0, a_in[IA*CK +: CK]});
		assign cb = $signed({(IB == NB - 1) ? b_in[BX-1] : 1'b0, b_in[IB*CK +: CK]});
		assign pp = PPW'(ca) * PPW'(cb);

		always_ff @(posedge clk) begin
			if (en) begin
				acc_r[s] <= acc_in + (PW'(pp) <<< ((IA + IB) * CK));
			end
		end

		if (s < NSTG - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					a_r[s] <= a_in;
					b_r[s] <= b_in;
				end
			end
		end
	end

	assign p = acc_r[NSTG-1][AW+BW-1:0];

endmodule

// ----- design/spt_det3.sv -----
// Pipelined 3x3 determinant by cofactor expansion along the first row.
// Depends on spt_pkg and spt_mul.
module spt_det3 #(
	parameter int EW = 118
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [EW-1:0]    m [9],
	output logic signed [3*EW+2:0]  r
);
	import spt_pkg::*;

	localparam int CW3 = 2 * EW + 1;
	localparam int TW  = CW3 + EW;
	localparam int OW  = 3 * EW + 3;
	localparam int N1  = mul_stages(EW, EW);
	localparam int N2  = mul_stages(CW3, EW);

	logic signed [2*EW-1:0] p [6];
	logic signed [CW3-1:0]  cof_s [3];
	logic signed [TW-1:0]   t [3];
	logic signed [EW-1:0]   row_dl [N1+1][3];
	logic signed [OW-1:0]   r_s;

	// Minor products of the lower two rows.
	spt_mul #(.AW(EW), .BW(EW)) u_p0 (.clk, .en, .a(m[4]), .b(m[8]), .p(p[0]));
	spt_mul #(.AW(EW), .BW(EW)) u_p1 (.clk, .en, .a(m[5]), .b(m[7]), .p(p[1]));
	spt_mul #(.AW(EW), .BW(EW)) u_p2 (.clk, .en, .a(m[3]), .b(m[8]), .p(p[2]));
	spt_mul #(.AW(EW), .BW(EW)) u_p3 (.clk, .en, .a(m[5]), .b(m[6]), .p(p[3]));
	spt_mul #(.AW(EW), .BW(EW)) u_p4 (.clk, .en, .a(m[3]), .b(m[7]), .p(p[4]));
	spt_mul #(.AW(EW), .BW(EW)) u_p5 (.clk, .en, .a(m[4]), .b(m[6]), .p(p[5]));

	// First-row entries wait until their cofactors are ready.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				row_dl[0][j] <= m[j];
			end
			for (int i = 1; i <= N1; i++) begin
				row_dl[i] <= row_dl[i-1];
			end
		end
	end

	// Cofactors.
	always_ff @(posedge clk) begin
		if (en) begin
			cof_s[0] <= CW3'(p[0]) - CW3'(p[1]);
			cof_s[1] <= CW3'(p[2]) - CW3'(p[3]);
			cof_s[2] <= CW3'(p[4]) - CW3'(p[5]);
		end
	end

	for (genvar j = 0; j < 3; j++) begin : g_top
		spt_mul #(.AW(CW3), .BW(EW)) u_t (
			.clk, .en, .a(cof_s[j]), .b(row_dl[N1][j]), .p(t[j])
		);
	end

	// Signed sum of the three terms.
	always_ff @(posedge clk) begin
		if (en) begin
			r_s <= OW'(t[0]) - OW'(t[1]) + OW'(t[2]);
		end
	end

	assign r = r_s;

endmodule

// ----- design/spt_div.sv -----
// Pipelined restoring divider: rounded Q.16 quotient with saturation.
// Depends on spt_pkg; one quotient bit per stage.
module spt_div #(
	parameter int DW = 357,
	parameter int QW = 40
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [DW-1:0]     num,
	input  logic signed [DW-1:0]     den,
	output logic signed [QW-1:0]     q,
	output spt_pkg::div_flags_t      flags
);
	import spt_pkg::*;

	localparam int RW  = DW + 2 + QW;
	localparam int RND = OUT_FRAC + 1;

	logic [DW-1:0] n_abs, d_abs;
	logic [RW-1:0] nn, dd;

	logic [RW-1:0] rem_s  [QW+1];
	logic [RW-1:0] dd_s   [QW+1];
	logic [QW-1:0] quo_s  [QW+1];
	logic          neg_s  [QW+1];
	logic          zero_s [QW+1];
	logic          big_s  [QW+1];

	logic [QW-1:0]        mag;
	logic signed [QW-1:0] q_s;
	div_flags_t           flags_s;

	// Magnitudes, rounding offset and the overflow check.
	assign n_abs = num[DW-1] ? (~num + 1'b1) : num;
	assign d_abs = den[DW-1] ? (~den + 1'b1) : den;
	assign nn    = (RW'(n_abs) << RND) + RW'(d_abs);
	assign dd    = RW'(d_abs) << 1;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= nn;
			dd_s[0]   <= dd;
			quo_s[0]  <= '0;
			neg_s[0]  <= num[DW-1] ^ den[DW-1];
			zero_s[0] <= (den == '0);
			big_s[0]  <= (nn >= (dd << QW));
		end
	end

	// One trial subtraction per stage, most significant bit first.
	for (genvar i = 1; i <= QW; i++) begin : g_bit
		logic [RW-1:0] shd;
		logic          ge;
		logic [QW-1:0] quo_n;

		assign shd = dd_s[i-1] << (QW - i);
		assign ge  = (rem_s[i-1] >= shd);

		always_comb begin
			quo_n = quo_s[i-1];
			quo_n[QW-i] = ge;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= ge ? (rem_s[i-1] - shd) : rem_s[i-1];
				dd_s[i]   <= dd_s[i-1];
				quo_s[i]  <= quo_n;
				neg_s[i]  <= neg_s[i-1];
				zero_s[i] <= zero_s[i-1];
				big_s[i]  <= big_s[i-1];
			end
		end
	end

	// Sign, saturation to the signed range and the result register.
	assign mag = quo_s[QW];

	always_ff @(posedge clk) begin
		if (en) begin
			flags_s.zero <= zero_s[QW];
			if (!neg_s[QW]) begin
				if (big_s[QW] || mag[QW-1]) begin
					q_s         <= {1'b0, {(QW-1){1'b1}}};
					flags_s.sat <= 1'b1;
				end else begin
					q_s         <= mag;
					flags_s.sat <= 1'b0;
				end
			end else begin
				if (big_s[QW] || (mag[QW-1] && (|mag[QW-2:0]))) begin
					q_s         <= {1'b1, {(QW-1){1'b0}}};
					flags_s.sat <= 1'b1;
				end else begin
					q_s         <= ~mag + 1'b1;
					flags_s.sat <= 1'b0;
				end
			end
		end
	end

	assign q     = q_s;
	assign flags = flags_s;

endmodule

// ----- test/tb.sv -----
// Self-checking bench for stereo_point_triangulator: loads camera matrices, solves point pairs
// and checks every result against an exact wide-integer predictor. Depends on spt_pkg.
module tb;
	import spt_pkg::*;

	localparam int CW = 40;
	localparam int PF = 4;
	localparam logic signed [CW-1:0] F_Q   = 40'sd52428800;   // 800.0
	localparam logic signed [CW-1:0] CX_Q  = 40'sd20971520;   // 320.0
	localparam logic signed [CW-1:0] CY_Q  = 40'sd15728640;   // 240.0
	localparam logic signed [CW-1:0] ONE_Q = 40'sd65536;      // 1.0
	localparam logic signed [CW-1:0] TX_Q  = -40'sd5242880;   // -f times baseline
	localparam logic signed [CW-1:0] MAX_Q = 40'sh7FFFFFFFFF;
	localparam logic signed [CW-1:0] MIN_Q = 40'sh8000000000;

	typedef logic signed [575:0] wide_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		status_t st;
	} point_t;

	typedef struct packed {
		logic cmd;
		logic [4:0] idx;
		logic signed [CW-1:0] val;
		logic [15:0] lu;
		logic [15:0] lv;
		logic [15:0] ru;
		logic [15:0] rv;
		logic typed;
		point_t res;
	} stim_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [111:0] s_tdata;
	logic s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [119:0] m_tdata;
	status_t m_tuser;

	logic signed [CW-1:0] coef_store [24];
	point_t pending_points[$];
	int err_count = 0;
	int n_sent = 0;
	bit no_gaps = 0;

	stereo_point_triangulator i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// Directed items: singular empty store, a rectified camera pair, ignored slot, extremes.
	localparam stim_t DIR_TAB [23] = '{
		'{CMD_SOLVE, 5'd0, 40'sd0, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1,
			'{40'sd0, 40'sd0, 40'sd0, STAT_SINGULAR}},
		'{CMD_LOAD, 5'd0, F_Q, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, '0},
		'{CMD_LOAD, 5'd2, CX_Q, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, '0},
		'{CMD_LOAD, 5'd5, F_Q, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, '0},
		'{CMD_LOAD, 5'd6, CY_Q, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, '0},
		'{CMD_LOAD, 5'd10, ONE_Q, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, '0},
		'{CMD_LOAD, 5'd12, F_Q, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, '0},
		'{CMD_LOAD, 5'd14, CX_Q, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, '0},
		'{CMD_LOAD, 5'd15, TX_Q, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, '0},
		'{CMD_LOAD, 5'd17, F_Q, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, '0},
		'{CMD_LOAD, 5'd18, CY_Q, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, '0},
		'{CMD_LOAD, 5'd22, ONE_Q, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, '0},
		'{CMD_SOLVE, 5'd0, 40'sd0, 16'd5120, 16'd3840, 16'd4800, 16'd3840, 1'b0, '0},
		'{CMD_SOLVE, 5'd0, 40'sd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0},
		'{CMD_SOLVE, 5'd0, 40'sd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, '0},
		'{CMD_LOAD, 5'd31, MAX_Q, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, '0},
		'{CMD_SOLVE, 5'd0, 40'sd0, 16'd5200, 16'd3900, 16'd5000, 16'd3900, 1'b0, '0},
		'{CMD_LOAD, 5'd3, MAX_Q, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, '0},
		'{CMD_SOLVE, 5'd0, 40'sd0, 16'd5120, 16'd3840, 16'd4800, 16'd3840, 1'b0, '0},
		'{CMD_LOAD, 5'd3, MIN_Q, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, '0},
		'{CMD_SOLVE, 5'd0, 40'sd0, 16'd1, 16'hFFFF, 16'd2, 16'd8, 1'b0, '0},
		'{CMD_LOAD, 5'd3, 40'sd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, '0},
		'{CMD_SOLVE, 5'd0, 40'sd0, 16'd5120, 16'd3840, 16'd5120, 16'd3840, 1'b0, '0}
	};

	// Clock and reset.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Run limit.
	initial begin
		#40000000;
		$display("tb: errors");
		$finish;
	end

	task automatic note_mismatch(input string what);
		$display("mismatch: %s", what);
		err_count++;
	endtask

	function automatic wide_t det3w(input wide_t m [3][3]);
		wide_t acc;
		acc = m[0][0] * (m[1][1] * m[2][2] - m[1][2] * m[2][1]);
		acc = acc - m[0][1] * (m[1][0] * m[2][2] - m[1][2] * m[2][0]);
		acc = acc + m[0][2] * (m[1][0] * m[2][1] - m[1][1] * m[2][0]);
		return acc;
	endfunction

	// Rounds num/den to nearest in Q.16 and clamps; returns 1 when clamped.
	function automatic bit round_coord(input wide_t num, input wide_t den,
			output logic signed [CW-1:0] coord);
		wide_t n;
		wide_t d;
		wide_t q;
		wide_t lim;
		bit neg;
		neg = (num < 0) != (den < 0);
		n = (num < 0) ? -num : num;
		d = (den < 0) ? -den : den;
		q = ((n <<< (OUT_FRAC + 1)) + d) / (d <<< 1);
		lim = wide_t'(1) <<< (CW - 1);
		if (!neg) begin
			if (q > lim - 1) begin
				coord = MAX_Q;
				return 1'b1;
			end
			coord = q[CW-1:0];
		end else begin
			if (q > lim) begin
				coord = MIN_Q;
				return 1'b1;
			end
			coord = -q[CW-1:0];
		end
		return 1'b0;
	endfunction

	// Least-squares point from the stored matrices via normal equations and Cramer's rule.
	function automatic point_t triangulate(input logic [15:0] px [4]);
		wide_t a [4][3];
		wide_t b [4];
		wide_t n [3][3];
		wide_t v [3];
		wide_t m [3][3];
		wide_t det;
		wide_t pw;
		wide_t t;
		wide_t mr;
		logic signed [CW-1:0] c [3];
		point_t res;
		bit sat;
		int base;
		sat = 1'b0;
		for (int k = 0; k < 4; k++) begin
			base = (k >= 2) ? 12 : 0;
			pw = wide_t'({1'b0, px[k]});
			for (int j = 0; j < 4; j++) begin
				t = pw * wide_t'(coef_store[base + 8 + j]);
				mr = wide_t'(coef_store[base + 4 * (k % 2) + j]) <<< PF;
				if (j < 3)
					a[k][j] = t - mr;
				else
					b[k] = mr - t;
			end
		end
		for (int i = 0; i < 3; i++) begin
			v[i] = 0;
			for (int j = 0; j < 3; j++)
				n[i][j] = 0;
			for (int k = 0; k < 4; k++) begin
				for (int j = 0; j < 3; j++)
					n[i][j] = n[i][j] + a[k][i] * a[k][j];
				v[i] = v[i] + a[k][i] * b[k];
			end
		end
		det = det3w(n);
		if (det == 0) begin
			res = '{40'sd0, 40'sd0, 40'sd0, STAT_SINGULAR};
			return res;
		end
		for (int k = 0; k < 3; k++) begin
			m = n;
			for (int i = 0; i < 3; i++)
				m[i][k] = v[i];
			if (round_coord(det3w(m), det, c[k]))
				sat = 1'b1;
		end
		res = '{c[0], c[1], c[2], sat ? STAT_SAT : STAT_OK};
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Drives one item at the falling edge and updates the prediction when it is taken.
	task automatic send_item(input stim_t it);
		logic [15:0] px [4];
		repeat (pick_gap()) @(negedge clk);
		s_tuser = it.cmd;
		s_tdata = {3'b0, it.rv, it.ru, it.lv, it.lu, it.val, it.idx};
		s_tvalid = 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		n_sent++;
		if (it.cmd == CMD_LOAD) begin
			if (it.idx < NUM_COEF)
				coef_store[it.idx] = it.val;
		end else if (it.typed) begin
			pending_points.push_back(it.res);
		end else begin
			px = '{it.lu, it.lv, it.ru, it.rv};
			pending_points.push_back(triangulate(px));
		end
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	function automatic logic signed [CW-1:0] rand_coef();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return CW'($signed(r[CW-1:0]) >>> $urandom_range(0, CW - 1));
	endfunction

	function automatic stim_t load_item(input int idx, input logic signed [CW-1:0] val);
		stim_t it;
		it = '0;
		it.cmd = CMD_LOAD;
		it.idx = idx[4:0];
		it.val = val;
		it.lu = 16'($urandom);
		it.rv = 16'($urandom);
		return it;
	endfunction

	// Loads a plausible rectified pair with random intrinsics and baseline.
	task automatic load_camera_pair();
		logic signed [CW-1:0] cam [24];
		logic signed [CW-1:0] f;
		f = CW'($urandom_range(100, 2000)) <<< 16;
		foreach (cam[i])
			cam[i] = ($urandom_range(0, 3) == 0) ? CW'($signed(12'($urandom))) : 40'sd0;
		cam[0] = f;
		cam[5] = f;
		cam[2] = CW'($urandom_range(100, 900)) <<< 16;
		cam[6] = CW'($urandom_range(100, 700)) <<< 16;
		cam[10] = ONE_Q;
		cam[12] = f;
		cam[17] = f;
		cam[14] = cam[2];
		cam[18] = cam[6];
		cam[22] = ONE_Q;
		cam[15] = -CW'($urandom_range(1, 500)) * (f >>> 6);
		for (int i = 0; i < 24; i++)
			send_item(load_item(i, cam[i]));
	endtask

	// Stimulus.
	initial begin
		stim_t it;
		int r;
		s_tvalid = 1'b0;
		s_tuser = CMD_LOAD;
		s_tdata = '0;
		foreach (coef_store[i])
			coef_store[i] = '0;
		@(posedge arst_n);
		@(negedge clk);
		for (int i = 0; i < NUM_COEF; i++)
			send_item(load_item(i, 40'sd0));
		foreach (DIR_TAB[i])
			send_item(DIR_TAB[i]);
		for (int n = 0; n_sent < 1700; n++) begin
			if (n % 200 == 0)
				no_gaps = ($urandom_range(0, 2) == 0);
			r = $urandom_range(0, 99);
			if (r < 3) begin
				load_camera_pair();
			end else if (r < 9) begin
				send_item(load_item($urandom_range(0, 23), rand_coef()));
			end else if (r < 11) begin
				send_item(load_item($urandom_range(24, 31), rand_coef()));
			end else begin
				it = '0;
				it.cmd = CMD_SOLVE;
				it.idx = 5'($urandom);
				it.val = rand_coef();
				if ($urandom_range(0, 3) == 0) begin
					it.lu = 16'($urandom);
					it.lv = 16'($urandom);
					it.ru = 16'($urandom);
					it.rv = 16'($urandom);
				end else begin
					it.lu = 16'($urandom_range(0, 16000));
					it.lv = 16'($urandom_range(0, 12000));
					it.ru = it.lu - 16'($urandom_range(0, 2000));
					it.rv = it.lv + 16'($urandom_range(0, 2)) - 16'd1;
				end
				send_item(it);
			end
		end
		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
		if (err_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

	// Receiver stalls.
	initial begin
		int r;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			r = $urandom_range(0, 99);
			if (no_gaps || r < 70) begin
				m_tready = 1'b1;
			end else begin
				m_tready = 1'b0;
				if (r > 96)
					repeat ($urandom_range(10, 40)) @(negedge clk);
			end
		end
	end

	// Result checking.
	always @(posedge clk) begin
		point_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_points.size() == 0) begin
				note_mismatch("result with nothing expected");
			end else begin
				want = pending_points.pop_front();
				if ($signed(m_tdata[CW-1:0]) != want.x)
					note_mismatch($sformatf("world_x %0d want %0d",
						$signed(m_tdata[CW-1:0]), want.x));
				if ($signed(m_tdata[2*CW-1:CW]) != want.y)
					note_mismatch($sformatf("world_y %0d want %0d",
						$signed(m_tdata[2*CW-1:CW]), want.y));
				if ($signed(m_tdata[3*CW-1:2*CW]) != want.z)
					note_mismatch($sformatf("world_z %0d want %0d",
						$signed(m_tdata[3*CW-1:2*CW]), want.z));
				if (m_tuser != want.st)
					note_mismatch($sformatf("status %0d want %0d", m_tuser, want.st));
			end
		end
	end

endmodule
